[src/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg: shared constants and helpers for the Euler-to-quaternion unit
// Holds the fixed-point formats, the CORDIC arctangent table and the
// rounding and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package e2q_pkg;

  localparam int CordicStages = 16;
  localparam int AngleBits    = 16;
  localparam int FracBits     = AngleBits - 3;
  localparam int ShQ          = 30 - FracBits;

  // CORDIC datapath width: Q30 values stay below 2^31 in magnitude.
  localparam int CW = 34;
  // Angle accumulator width.
  localparam int ZW = FracBits + 5;

  typedef logic signed [15:0] q16_t;
  typedef logic signed [CW-1:0] cord_t;
  typedef logic signed [ZW-1:0] zang_t;

  localparam logic signed [63:0] GainQ30   = 64'sd652032874;
  localparam logic signed [63:0] PiQ30     = 64'sd3373259426;
  localparam logic signed [63:0] HalfPiQ30 = 64'sd1686629713;

  function automatic logic signed [63:0] atan_q30(input int i);
    logic signed [63:0] r;
    begin
      case (i)
        0:  r = 64'sh3243F6A8;
        1:  r = 64'sh1DAC6705;
        2:  r = 64'sh0FADBAFC;
        3:  r = 64'sh07F56EA6;
        4:  r = 64'sh03FEAB76;
        5:  r = 64'sh01FFD55B;
        6:  r = 64'sh00FFFAAA;
        7:  r = 64'sh007FFF55;
        8:  r = 64'sh003FFFEA;
        9:  r = 64'sh001FFFFD;
        default: r = 64'sh40000000 >>> i;
      endcase
      return r;
    end
  endfunction

  // Round a Q30 constant to the angle format (add half an LSB, then floor).
  function automatic zang_t rnd_const(input logic signed [63:0] v);
    logic signed [63:0] t;
    begin
      if (ShQ == 0) t = v;
      else t = (v + (64'sd1 <<< (ShQ - 1))) >>> ShQ;
      return t[ZW-1:0];
    end
  endfunction

  // Saturate to the closed range of plus or minus one in Q1.14.
  function automatic q16_t sat_one(input logic signed [47:0] v);
    begin
      if (v > 48'sd16384) return 16'sd16384;
      else if (v < -48'sd16384) return -16'sd16384;
      else return v[15:0];
    end
  endfunction

endpackage
`default_nettype wire

[src/euler_to_quaternion_unit.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit: Z-Y-X Euler angles to unit quaternion
// Pipelined CORDIC half-angle sine/cosine followed by a product tree.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries heading, pitch and
// roll as signed Q3.13 radians. The output channel (out_valid/out_ready)
// carries w, x, y, z as signed Q1.14, saturated to plus or minus one.
// Every input transfer yields exactly one output transfer, in order.
// The pipeline has one fold stage, one CORDIC stage per iteration, one
// rounding stage, then three stages of multiplies and sums. Throughput is
// one item per cycle while the receiver does not stall.
// The whole pipeline advances as one unit; a valid bit travels with each
// stage. When the receiver stalls and the last stage holds a result, the
// pipeline freezes and in_ready drops; empty slots (bubbles) are not
// squeezed out while it is frozen, since every stage moves only when the
// output is free or being taken.
// Reset (rst_n low, synchronous) clears the valid bits only; the data
// registers carry no reset. The block keeps no state between items.
// ----------------------------------------------------------------------------
`default_nettype none
module euler_to_quaternion_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire e2q_pkg::q16_t in_heading_angle,
  input  wire e2q_pkg::q16_t in_pitch_angle,
  input  wire e2q_pkg::q16_t in_roll_angle,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output e2q_pkg::q16_t      out_quat_w,
  output e2q_pkg::q16_t      out_quat_x,
  output e2q_pkg::q16_t      out_quat_y,
  output e2q_pkg::q16_t      out_quat_z
);
  import e2q_pkg::*;

  localparam int Depth = CordicStages + 5;

  logic [Depth-1:0] vld_r, vld_nxt;
  logic en;

  // Advance whenever the final stage is empty or being drained.
  assign en       = !vld_r[Depth-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[Depth-1];

  always_comb begin
    vld_nxt = vld_r;
    if (en) vld_nxt = {vld_r[Depth-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  q16_t sps, cps, sth, cth, sph, cph;

  e2q_cordic u_psi (.clk(clk), .en(en), .angle(in_heading_angle),
                    .sin_q(sps), .cos_q(cps));
  e2q_cordic u_th  (.clk(clk), .en(en), .angle(in_pitch_angle),
                    .sin_q(sth), .cos_q(cth));
  e2q_cordic u_phi (.clk(clk), .en(en), .angle(in_roll_angle),
                    .sin_q(sph), .cos_q(cph));

  e2q_combine u_comb (
    .clk(clk), .en(en),
    .sps(sps), .cps(cps), .sth(sth), .cth(cth), .sph(sph), .cph(cph),
    .qw(out_quat_w), .qx(out_quat_x), .qy(out_quat_y), .qz(out_quat_z)
  );
endmodule
`default_nettype wire

[src/e2q_cordic.sv]
// ----------------------------------------------------------------------------
// e2q_cordic: pipelined half-angle sine/cosine
// One CORDIC stage per register stage, with a fold stage ahead and a
// rounding stage behind. Advances when en is high.
// ----------------------------------------------------------------------------
`default_nettype none
module e2q_cordic (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire e2q_pkg::q16_t   angle,
  output e2q_pkg::q16_t        sin_q,
  output e2q_pkg::q16_t        cos_q
);
  import e2q_pkg::*;

  zang_t z_r   [CordicStages+1];
  cord_t x_r   [CordicStages+1];
  cord_t y_r   [CordicStages+1];
  logic  neg_r [CordicStages+1];
  q16_t  sin_r, cos_r;

  zang_t z_in, z_fold, pi_f, hpi_f;
  logic  neg_in;

  always_comb begin
    pi_f  = rnd_const(PiQ30);
    hpi_f = rnd_const(HalfPiQ30);
    if (FracBits >= 14) begin
      z_in = zang_t'(angle) <<< (FracBits - 14);
    end else begin
      z_in = (zang_t'(angle) + (zang_t'(1) <<< (13 - FracBits))) >>> (14 - FracBits);
    end
    neg_in = 1'b0;
    z_fold = z_in;
    if (z_in > hpi_f) begin
      z_fold = z_in - pi_f;
      neg_in = 1'b1;
    end else if (z_in < -hpi_f) begin
      z_fold = z_in + pi_f;
      neg_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]   <= z_fold;
      x_r[0]   <= cord_t'(GainQ30);
      y_r[0]   <= '0;
      neg_r[0] <= neg_in;
    end
  end

  for (genvar i = 0; i < CordicStages; i++) begin : g_stage
    cord_t xs, ys;
    zang_t t;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign t  = rnd_const(atan_q30(i));
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - t;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + t;
        end
      end
    end
  end

  cord_t xf, yf;
  logic signed [47:0] xr, yr;
  always_comb begin
    xf = neg_r[CordicStages] ? -x_r[CordicStages] : x_r[CordicStages];
    yf = neg_r[CordicStages] ? -y_r[CordicStages] : y_r[CordicStages];
    xr = (48'(xf) + 48'sd32768) >>> 16;
    yr = (48'(yf) + 48'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= sat_one(xr);
      sin_r <= sat_one(yr);
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;
endmodule
`default_nettype wire

[src/e2q_combine.sv]
// ----------------------------------------------------------------------------
// e2q_combine: triple products and final rounding
// Stage one forms pair products, stage two the triple products, stage
// three the sums rounded to Q1.14 with saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module e2q_combine (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire e2q_pkg::q16_t sps, cps, sth, cth, sph, cph,
  output e2q_pkg::q16_t      qw, qx, qy, qz
);
  import e2q_pkg::*;

  typedef logic signed [31:0] p2_t;
  typedef logic signed [47:0] p3_t;

  p2_t cc_r, ss_r, cs_r, sc_r;
  q16_t sph_r, cph_r;
  p3_t ccc_r, sss_r, ccs_r, ssc_r, csc_r, scs_r, scc_r, css_r;
  q16_t w_r, x_r, y_r, z_r;

  function automatic q16_t fin(input p3_t v);
    p3_t r;
    begin
      r = (v + 48'sd134217728) >>> 28;
      return sat_one(r);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r  <= cps * cth;
      ss_r  <= sps * sth;
      cs_r  <= cps * sth;
      sc_r  <= sps * cth;
      sph_r <= sph;
      cph_r <= cph;
      ccc_r <= cc_r * cph_r;
      sss_r <= ss_r * sph_r;
      ccs_r <= cc_r * sph_r;
      ssc_r <= ss_r * cph_r;
      csc_r <= cs_r * cph_r;
      scs_r <= sc_r * sph_r;
      scc_r <= sc_r * cph_r;
      css_r <= cs_r * sph_r;
      w_r   <= fin(ccc_r + sss_r);
      x_r   <= fin(ccs_r - ssc_r);
      y_r   <= fin(csc_r + scs_r);
      z_r   <= fin(scc_r - css_r);
    end
  end

  assign qw = w_r;
  assign qx = x_r;
  assign qy = y_r;
  assign qz = z_r;
endmodule
`default_nettype wire

[src/e2q_checker.sv]
// ----------------------------------------------------------------------------
// e2q_checker: port-level checks for the Euler-to-quaternion unit
// Watches the handshakes and output ranges over time.
// ----------------------------------------------------------------------------
`default_nettype none
module e2q_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire e2q_pkg::q16_t out_quat_w,
  input wire e2q_pkg::q16_t out_quat_x
);
  import e2q_pkg::*;

  // A stalled result holds its w and x values.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quat_w) && $stable(out_quat_x))
    else $error("stalled result changed");

  // Input is ready whenever the output is taken.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready) else $error("ready lost while output drains");

  // No result right after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  // The w component stays in range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_quat_w <= 16'sd16384 && out_quat_w >= -16'sd16384)
    else $error("w out of range");
endmodule

bind euler_to_quaternion_unit e2q_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_quat_w(out_quat_w), .out_quat_x(out_quat_x)
);
`default_nettype wire

[test/euler_to_quaternion_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit_tb: self-checking bench for the Euler-to-quaternion unit
// Drives heading/pitch/roll angles through valid/ready, predicts each
// quaternion with an independent half-angle CORDIC model and checks every
// result in order under several idle and stall patterns.
// ----------------------------------------------------------------------------

// Predicts quaternions from accepted angles and matches them against output.
class quat_scoreboard;
  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  quat_t pending_quats[$];
  int    mismatch_count;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint arctan_q30(int i);
    longint tbl[10] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                        64'h003FFFEA, 64'h001FFFFD};
    if (i < 10) return tbl[i];
    return 64'sh40000000 >>> i;
  endfunction

  // Sine and cosine of half of a Q3.13 angle, both in Q1.14.
  function automatic void half_angle_sincos(logic signed [15:0] angle,
                                            output longint sn, output longint cs);
    longint z, x, y, xs, ys, t, pi_f, hpi_f;
    bit flip;
    flip = 0;
    // Read as Q2.14, the raw value is the half angle; 13 fraction bits kept.
    z = round_sh(longint'(angle), 1);
    pi_f = round_sh(64'sd3373259426, 17);
    hpi_f = round_sh(64'sd1686629713, 17);
    // Fold half angles beyond a quarter turn and negate the outputs.
    if (z > hpi_f) begin
      z -= pi_f;
      flip = 1;
    end else if (z < -hpi_f) begin
      z += pi_f;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = floor_sh(x, i);
      ys = floor_sh(y, i);
      t = round_sh(arctan_q30(i), 17);
      if (z >= 0) begin
        x -= ys; y += xs; z -= t;
      end else begin
        x += ys; y -= xs; z += t;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = clamp_one(round_sh(x, 16));
    sn = clamp_one(round_sh(y, 16));
  endfunction

  function automatic logic signed [15:0] to_q14(longint q42);
    longint r;
    r = clamp_one(round_sh(q42, 28));
    return r[15:0];
  endfunction

  function void note_angles(logic signed [15:0] hd, logic signed [15:0] pt,
                            logic signed [15:0] rl);
    longint sps, cps, sth, cth, sph, cph;
    quat_t q;
    half_angle_sincos(hd, sps, cps);
    half_angle_sincos(pt, sth, cth);
    half_angle_sincos(rl, sph, cph);
    q.w = to_q14(cps * cth * cph + sps * sth * sph);
    q.x = to_q14(cps * cth * sph - sps * sth * cph);
    q.y = to_q14(cps * sth * cph + sps * cth * sph);
    q.z = to_q14(sps * cth * cph - cps * sth * sph);
    pending_quats.push_back(q);
  endfunction

  function void check_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    quat_t e;
    if (pending_quats.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result w=%0d x=%0d y=%0d z=%0d", w, x, y, z);
      return;
    end
    e = pending_quats.pop_front();
    if (e.w !== w || e.x !== x || e.y !== y || e.z !== z) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("quat mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                 e.w, e.x, e.y, e.z, w, x, y, z);
    end
  endfunction
endclass

module euler_to_quaternion_unit_tb;
  import e2q_pkg::*;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  q16_t  in_heading_angle, in_pitch_angle, in_roll_angle;
  logic  out_valid;
  logic  out_ready;
  q16_t  out_quat_w, out_quat_x, out_quat_y, out_quat_z;

  // Idle percentages for the sender and stall percentages for the receiver.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  quat_scoreboard quat_sb;

  euler_to_quaternion_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_heading_angle(in_heading_angle), .in_pitch_angle(in_pitch_angle),
    .in_roll_angle(in_roll_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Initial values so no port ever floats at time zero.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_heading_angle = '0;
    in_pitch_angle = '0;
    in_roll_angle = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quat_sb = new();
  end

  // The receiver decides ready once per edge; one assignment per step.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output transfers are sampled at the edge where valid and ready are high.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      quat_sb.check_quat(out_quat_w, out_quat_x, out_quat_y, out_quat_z);
  end

  // Offers one item, honoring the idle rate, and returns once it transfers.
  // Valid stays high between back-to-back items so it is never dropped and
  // raised in the same step.
  task automatic send_angles(q16_t hd, q16_t pt, q16_t rl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_heading_angle <= hd;
    in_pitch_angle <= pt;
    in_roll_angle <= rl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    quat_sb.note_angles(hd, pt, rl);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (quat_sb.pending_quats.size() != 0) @(posedge clk);
  endtask

  // Random angle: mostly uniform, sometimes near plus or minus pi/2 or at the extremes.
  function automatic q16_t pick_angle();
    case ($urandom_range(7))
      0: return q16_t'(16'sd12868 + $signed($urandom_range(64)) - 32);
      1: return q16_t'(-16'sd12868 + $signed($urandom_range(64)) - 32);
      2: return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
      default: return q16_t'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    q16_t edge_vals[12];
    edge_vals = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF,
                  16'sd12867, 16'sd12868, 16'sd12869, -16'sd12867, -16'sd12868,
                  -16'sd12869, 16'sd25736};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: heading alone, then pitch with roll, at the extremes, near plus or minus pi/2 and at pi.
    foreach (edge_vals[i]) send_angles(edge_vals[i], 16'sh0, 16'sh0);
    for (int i = 0; i < 12; i += 2) send_angles(16'sh0, edge_vals[i], edge_vals[i + 1]);
    send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
    // Pause until every expected quaternion has come out.
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      repeat (200) send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    drain_results();
    recv_stall_pct = 0;
    repeat (30) @(posedge clk);

    if (quat_sb.mismatch_count == 0 && quat_sb.pending_quats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[sim.f]
src/e2q_pkg.sv
src/e2q_cordic.sv
src/e2q_combine.sv
src/euler_to_quaternion_unit.sv
src/e2q_checker.sv
test/euler_to_quaternion_unit_tb.sv
